@@ src/lavm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and constants for the look-at view matrix core
// Unit vector width, column indexes and helper functions.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int UNIT_BITS = 30;
  localparam int POS_W     = 32;

  // Column indexes
  localparam logic [1:0] COL_FIRST = 2'd0;
  localparam logic [1:0] COL_LAST  = 2'd3;

  // Unit vector, Q2.30, magnitude at most 2^30
  typedef logic signed [31:0] unit_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } uvec_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage : lavm_pkg
`default_nettype wire

@@ src/lavm_unitize.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_unitize: pipelined vector normalizer
// Scales so the largest magnitude lies in [2^29, 2^30), sums squares,
// bit-serial-per-stage square root and three pipelined restoring dividers.
// Stages: four front stages, 32 root stages and 32 divide stages.
// ----------------------------------------------------------------------------
module lavm_unitize #(
  parameter int IN_W = 64,
  parameter int SB_W = 1
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    en,
  input  wire                    in_valid,
  input  wire signed [IN_W-1:0]  in_x,
  input  wire signed [IN_W-1:0]  in_y,
  input  wire signed [IN_W-1:0]  in_z,
  input  wire        [SB_W-1:0]  in_sb,
  output logic                   out_valid,
  output lavm_pkg::uvec_t        out_u,
  output logic       [SB_W-1:0]  out_sb
);

  localparam int UB    = lavm_pkg::UNIT_BITS;
  localparam int MW    = 31;          // scaled magnitude width
  localparam int SW    = 64;          // sum of squares width
  localparam int RW    = 32;          // root width
  localparam int SQ_ST = RW;          // one root bit per stage
  localparam int NW    = MW + UB + 2; // numerator width
  localparam int QW    = 32;          // quotient bits
  localparam int DV_ST = QW;          // one quotient bit per stage
  localparam int LW    = $clog2(IN_W + 1);

  typedef struct packed {
    logic            v;
    logic [SB_W-1:0] sb;
    logic [2:0]      neg;
  } ctl_t;

  // ---------------- stage A: magnitudes and leading-one position
  ctl_t            a_c;
  logic [IN_W-1:0] a_m [3];
  logic [LW-1:0]   a_lz;
  logic [IN_W-1:0] mx, my, mz, mtop;
  logic [LW-1:0]   lead;

  always_comb begin
    mx = in_x[IN_W-1] ? IN_W'(-in_x) : in_x;
    my = in_y[IN_W-1] ? IN_W'(-in_y) : in_y;
    mz = in_z[IN_W-1] ? IN_W'(-in_z) : in_z;
    mtop = mx | my | mz;
    lead = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mtop[i]) begin
        lead = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_c.v <= 1'b0;
    end else if (en) begin
      a_c.v <= in_valid;
    end
    if (en) begin
      a_c.sb  <= in_sb;
      a_c.neg <= {in_z[IN_W-1], in_y[IN_W-1], in_x[IN_W-1]};
      a_m[0]  <= mx;
      a_m[1]  <= my;
      a_m[2]  <= mz;
      a_lz    <= lead;
    end
  end

  // ---------------- stage B: scale so top bit sits at UB-1
  ctl_t          b_c;
  logic [MW-1:0] b_m [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_c.v <= 1'b0;
    end else if (en) begin
      b_c.v <= a_c.v;
    end
    if (en) begin
      b_c.sb  <= a_c.sb;
      b_c.neg <= a_c.neg;
      for (int i = 0; i < 3; i++) begin
        if (32'(a_lz) >= UB) begin
          b_m[i] <= MW'(a_m[i] >> (32'(a_lz) - (UB - 1)));
        end else begin
          b_m[i] <= MW'(a_m[i] << ((UB - 1) - 32'(a_lz)));
        end
      end
    end
  end

  // ---------------- stage C: squares
  ctl_t          c_c;
  logic [MW-1:0] c_m [3];
  logic [SW-1:0] c_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_c.v <= 1'b0;
    end else if (en) begin
      c_c.v <= b_c.v;
    end
    if (en) begin
      c_c.sb  <= b_c.sb;
      c_c.neg <= b_c.neg;
      for (int i = 0; i < 3; i++) begin
        c_m[i]  <= b_m[i];
        c_sq[i] <= SW'(b_m[i]) * SW'(b_m[i]);
      end
    end
  end

  // ---------------- stage D: sum
  ctl_t          d_c;
  logic [MW-1:0] d_m [3];
  logic [SW-1:0] d_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_c.v <= 1'b0;
    end else if (en) begin
      d_c.v <= c_c.v;
    end
    if (en) begin
      d_c.sb  <= c_c.sb;
      d_c.neg <= c_c.neg;
      d_m     <= c_m;
      d_s     <= c_sq[0] + c_sq[1] + c_sq[2];
    end
  end

  // ---------------- square root, one result bit per stage
  ctl_t          q_c   [SQ_ST+1];
  logic [MW-1:0] q_m   [SQ_ST+1][3];
  logic [SW-1:0] q_rem [SQ_ST+1];
  logic [RW-1:0] q_r   [SQ_ST+1];

  always_comb begin
    q_c[0]   = d_c;
    q_m[0]   = d_m;
    q_rem[0] = d_s;
    q_r[0]   = '0;
  end

  for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
    localparam int BP = 2 * (RW - 1 - k);
    logic [SW+1:0] trial;
    always_comb begin
      trial = ({2'b00, q_rem[k]}) -
              (((SW+2)'(q_r[k]) << (RW - k)) | ((SW+2)'(1) << BP));
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        q_c[k+1].v <= 1'b0;
      end else if (en) begin
        q_c[k+1].v <= q_c[k].v;
      end
      if (en) begin
        q_c[k+1].sb  <= q_c[k].sb;
        q_c[k+1].neg <= q_c[k].neg;
        q_m[k+1]     <= q_m[k];
        if (!trial[SW+1]) begin
          q_rem[k+1] <= trial[SW-1:0];
          q_r[k+1]   <= q_r[k] | (RW'(1) << (RW - 1 - k));
        end else begin
          q_rem[k+1] <= q_rem[k];
          q_r[k+1]   <= q_r[k];
        end
      end
    end
  end

  // ---------------- divide: q = (m*2^(UB+1) + r) / (2r), per stage one bit
  ctl_t          v_c   [DV_ST+1];
  logic [NW-1:0] v_rem [DV_ST+1][3];
  logic [QW-1:0] v_q   [DV_ST+1][3];
  logic [RW:0]   v_den [DV_ST+1];

  always_comb begin
    v_c[0]   = q_c[SQ_ST];
    v_den[0] = {q_r[SQ_ST], 1'b0};
    for (int i = 0; i < 3; i++) begin
      v_rem[0][i] = (NW'(q_m[SQ_ST][i]) << (UB + 1)) + NW'(q_r[SQ_ST]);
      v_q[0][i]   = '0;
    end
  end

  for (genvar k = 0; k < DV_ST; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_c[k+1].v <= 1'b0;
      end else if (en) begin
        v_c[k+1].v <= v_c[k].v;
      end
      if (en) begin
        v_c[k+1].sb  <= v_c[k].sb;
        v_c[k+1].neg <= v_c[k].neg;
        v_den[k+1]   <= v_den[k];
        for (int i = 0; i < 3; i++) begin
          if ((v_rem[k][i] >> SH) >= NW'(v_den[k])) begin
            v_rem[k+1][i] <= v_rem[k][i] - (NW'(v_den[k]) << SH);
            v_q[k+1][i]   <= v_q[k][i] | (QW'(1) << SH);
          end else begin
            v_rem[k+1][i] <= v_rem[k][i];
            v_q[k+1][i]   <= v_q[k][i];
          end
        end
      end
    end
  end

  // ---------------- sign and output (zero vector gives root 0 -> zero out)
  logic [QW-1:0] fq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fq[i] = (v_den[DV_ST] == '0) ? '0 : v_q[DV_ST][i];
    end
    out_valid = v_c[DV_ST].v;
    out_sb    = v_c[DV_ST].sb;
    out_u.x   = v_c[DV_ST].neg[0] ? -$signed(fq[0]) : $signed(fq[0]);
    out_u.y   = v_c[DV_ST].neg[1] ? -$signed(fq[1]) : $signed(fq[1]);
    out_u.z   = v_c[DV_ST].neg[2] ? -$signed(fq[2]) : $signed(fq[2]);
  end

endmodule : lavm_unitize
`default_nettype wire

@@ src/look_at_view_matrix_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: column-major look-at view matrix builder
// Camera position and target in, four matrix columns out.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one beat per camera: position and target, signed Q.FRAC_BITS.
//  m_axis gives four beats per input, columns 0..3, tlast on column 3.
//  tuser flags a degenerate view (zero direction or parallel to world up);
//  all entries are then zero.
//  The datapath is a stall-able pipeline of two normalizer passes (68
//  stages each) plus cross product and dot product stages; column 0 of an
//  accepted input beat is offered on m_axis once it has passed the
//  difference stage, both passes, the product stages and the final matrix
//  register, and columns 1..3 follow one per cycle while m_axis_tready is
//  high. The pipeline advances when no finished matrix is held or its last
//  column leaves, so no new input enters while earlier columns remain.
//  While the serializer still has columns to send, the pipeline holds and
//  s_axis_tready drops; nothing is lost or repeated.
//  Reset (rst, synchronous) clears all valid bits and the serializer.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // cam_x, cam_y, cam_z, target_x, target_y, target_z
  input  wire  [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // column_index[1:0], pad, entry_row0..3 at [39:8],[71:40],[103:72],[135:104]
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // degenerate
  output logic         m_axis_tuser
);

  localparam int UB  = lavm_pkg::UNIT_BITS;
  localparam int PW  = lavm_pkg::POS_W;

  // serializer / pipeline enable
  logic        en;
  logic        hold_v;
  logic [1:0]  col;
  logic        fin_v;

  // ---------------- stage 0: differences
  logic signed [PW-1:0] cx, cy, cz, tx, ty, tz;
  assign cx = s_axis_tdata[31:0];
  assign cy = s_axis_tdata[63:32];
  assign cz = s_axis_tdata[95:64];
  assign tx = s_axis_tdata[127:96];
  assign ty = s_axis_tdata[159:128];
  assign tz = s_axis_tdata[191:160];

  logic                 s0_v, s0_dg;
  logic signed [PW:0]   s0_dx, s0_dy, s0_dz;
  logic signed [PW-1:0] s0_p [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_axis_tvalid;
    end
    if (en) begin
      s0_dx  <= (PW+1)'(tx) - (PW+1)'(cx);
      s0_dy  <= (PW+1)'(ty) - (PW+1)'(cy);
      s0_dz  <= (PW+1)'(tz) - (PW+1)'(cz);
      s0_dg  <= (tx == cx) && (tz == cz);
      s0_p[0] <= cx;
      s0_p[1] <= cy;
      s0_p[2] <= cz;
    end
  end

  // ---------------- pass 1: dir and right normalized in parallel
  localparam int SBA = 1 + 3 * PW;
  logic [SBA-1:0]   sb_in, sb_d, sb_r;
  logic             d_v, r_v;
  lavm_pkg::uvec_t  u_dir, u_rt;

  assign sb_in = {s0_dg, s0_p[2], s0_p[1], s0_p[0]};

  lavm_unitize #(.IN_W(PW + 1), .SB_W(SBA)) u_dir_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_v),
    .in_x(s0_dx), .in_y(s0_dy), .in_z(s0_dz), .in_sb(sb_in),
    .out_valid(d_v), .out_u(u_dir), .out_sb(sb_d)
  );

  lavm_unitize #(.IN_W(PW + 1), .SB_W(SBA)) u_rt_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_v),
    .in_x(-s0_dz), .in_y('0), .in_z(s0_dx), .in_sb(sb_in),
    .out_valid(r_v), .out_u(u_rt), .out_sb(sb_r)
  );

  // ---------------- cross product: products, then differences
  logic                 x1_v, x2_v;
  logic signed [63:0]   xp [6];
  logic signed [64:0]   xu [3];
  lavm_pkg::uvec_t      x1_d, x1_r, x2_d, x2_r;
  logic [SBA-1:0]       x1_sb, x2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
    end else if (en) begin
      x1_v <= d_v;
      x2_v <= x1_v;
    end
    if (en) begin
      xp[0] <= u_rt.y * u_dir.z;
      xp[1] <= u_dir.y * u_rt.z;
      xp[2] <= u_rt.z * u_dir.x;
      xp[3] <= u_dir.z * u_rt.x;
      xp[4] <= u_rt.x * u_dir.y;
      xp[5] <= u_dir.x * u_rt.y;
      x1_d  <= u_dir;
      x1_r  <= u_rt;
      x1_sb <= sb_d;
      xu[0] <= 65'(xp[0]) - 65'(xp[1]);
      xu[1] <= 65'(xp[2]) - 65'(xp[3]);
      xu[2] <= 65'(xp[4]) - 65'(xp[5]);
      x2_d  <= x1_d;
      x2_r  <= x1_r;
      x2_sb <= x1_sb;
    end
  end

  // ---------------- pass 2: up' normalized, dir/right ride along
  localparam int SBB = SBA + 6 * 32;
  logic [SBB-1:0]  sb2_in, sb2_out;
  logic            u_v;
  lavm_pkg::uvec_t u_up, p_d, p_r;
  logic [SBA-1:0]  p_sb;

  assign sb2_in = {x2_sb, x2_d, x2_r};

  lavm_unitize #(.IN_W(65), .SB_W(SBB)) u_up_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(x2_v),
    .in_x(xu[0]), .in_y(xu[1]), .in_z(xu[2]), .in_sb(sb2_in),
    .out_valid(u_v), .out_u(u_up), .out_sb(sb2_out)
  );

  assign {p_sb, p_d, p_r} = sb2_out;

  // ---------------- dot products: nine products, then sums, then round
  logic signed [PW-1:0] pp [3];
  assign pp[0] = p_sb[PW-1:0];
  assign pp[1] = p_sb[2*PW-1:PW];
  assign pp[2] = p_sb[3*PW-1:2*PW];

  logic                 m1_v, m2_v;
  logic signed [63:0]   dm [3][3];
  logic signed [65:0]   ds [3];
  lavm_pkg::uvec_t      m1_d, m1_r, m1_u, m2_d, m2_r, m2_u;
  logic                 m1_g, m2_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= u_v;
      m2_v <= m1_v;
    end
    if (en) begin
      dm[0][0] <= p_r.x * pp[0];
      dm[0][1] <= p_r.y * pp[1];
      dm[0][2] <= p_r.z * pp[2];
      dm[1][0] <= u_up.x * pp[0];
      dm[1][1] <= u_up.y * pp[1];
      dm[1][2] <= u_up.z * pp[2];
      dm[2][0] <= p_d.x * pp[0];
      dm[2][1] <= p_d.y * pp[1];
      dm[2][2] <= p_d.z * pp[2];
      m1_d <= p_d;
      m1_r <= p_r;
      m1_u <= u_up;
      m1_g <= p_sb[SBA-1];
      ds[0] <= -(66'(dm[0][0]) + 66'(dm[0][1]) + 66'(dm[0][2]));
      ds[1] <= -(66'(dm[1][0]) + 66'(dm[1][1]) + 66'(dm[1][2]));
      ds[2] <= 66'(dm[2][0]) + 66'(dm[2][1]) + 66'(dm[2][2]);
      m2_d <= m1_d;
      m2_r <= m1_r;
      m2_u <= m1_u;
      m2_g <= m1_g;
    end
  end

  // round to nearest, ties away from zero, by sh bits
  function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int sh);
    logic [71:0] m;
    m = v[71] ? 72'(-v) : 72'(v);
    if (sh > 0) begin
      m = (m + (72'(1) << (sh - 1))) >> sh;
    end
    rnd = v[71] ? -$signed(m) : $signed(m);
  endfunction

  // ---------------- final matrix register
  logic signed [31:0] mat [4][4];
  logic               fin_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= m2_v;
    end
    if (en) begin
      fin_g <= m2_g;
      if (m2_g) begin
        for (int j = 0; j < 4; j++) begin
          for (int i = 0; i < 4; i++) begin
            mat[j][i] <= '0;
          end
        end
      end else begin
        mat[0][0] <= lavm_pkg::sat32(rnd(72'(m2_r.x), UB - FRAC_BITS));
        mat[1][0] <= lavm_pkg::sat32(rnd(72'(m2_r.y), UB - FRAC_BITS));
        mat[2][0] <= lavm_pkg::sat32(rnd(72'(m2_r.z), UB - FRAC_BITS));
        mat[0][1] <= lavm_pkg::sat32(rnd(72'(m2_u.x), UB - FRAC_BITS));
        mat[1][1] <= lavm_pkg::sat32(rnd(72'(m2_u.y), UB - FRAC_BITS));
        mat[2][1] <= lavm_pkg::sat32(rnd(72'(m2_u.z), UB - FRAC_BITS));
        mat[0][2] <= lavm_pkg::sat32(rnd(-72'(m2_d.x), UB - FRAC_BITS));
        mat[1][2] <= lavm_pkg::sat32(rnd(-72'(m2_d.y), UB - FRAC_BITS));
        mat[2][2] <= lavm_pkg::sat32(rnd(-72'(m2_d.z), UB - FRAC_BITS));
        mat[0][3] <= '0;
        mat[1][3] <= '0;
        mat[2][3] <= '0;
        mat[3][0] <= lavm_pkg::sat32(rnd(72'(ds[0]), UB));
        mat[3][1] <= lavm_pkg::sat32(rnd(72'(ds[1]), UB));
        mat[3][2] <= lavm_pkg::sat32(rnd(72'(ds[2]), UB));
        mat[3][3] <= 32'sd1 <<< FRAC_BITS;
      end
    end
  end

  // ---------------- column serializer
  // Pipeline moves when no finished matrix is held, or the last column leaves.
  assign hold_v = fin_v;
  assign en = !hold_v || (m_axis_tready && col == lavm_pkg::COL_LAST);
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= lavm_pkg::COL_FIRST;
    end else if (hold_v && m_axis_tready) begin
      col <= col + 2'd1;
    end
  end

  assign m_axis_tvalid = hold_v;
  assign m_axis_tlast  = (col == lavm_pkg::COL_LAST);
  assign m_axis_tuser  = fin_g;
  assign m_axis_tdata  = {mat[col][3], mat[col][2], mat[col][1], mat[col][0],
                          6'b0, col};

  // ---------------- checks
  a_col_reset: assert property (@(posedge clk) rst |=> col == lavm_pkg::COL_FIRST)
    else $error("column counter not cleared");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(col))
    else $error("column lost under stall");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("matrix dropped mid-columns");
  a_norm_align: assert property (@(posedge clk) disable iff (rst)
    (r_v == d_v) && (!d_v || sb_r == sb_d))
    else $error("dir and right normalizers out of step");

endmodule : look_at_view_matrix_core
`default_nettype wire
